FILE: src/lpid_pkg.sv
// Shared types and codes for the linear probing id table.
package lpid_pkg;

  localparam logic [1:0] OP_ASSIGN = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_RETIRE = 2'd2;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_ACTIVE  = 2'd1;
  localparam logic [1:0] SLOT_RETIRED = 2'd2;

  localparam int KEY_W = 32;
  localparam int ID_W  = 32;
  localparam int HASH_SHIFT = 4;
  localparam int HASH_W = KEY_W - HASH_SHIFT;
  localparam int MOD_BITS = 4;
  localparam int MOD_STEPS = HASH_W / MOD_BITS;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

endpackage

FILE: src/lpid_req_if.sv
// Request channel: operation code and key.
interface lpid_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

FILE: src/lpid_rsp_if.sv
// Response channel: assigned or found id.
interface lpid_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] id;

  modport source (output valid, output id, input ready);
  modport sink (input valid, input id, output ready);
endinterface

FILE: src/lpid_ram.sv
// Generic simple dual port RAM with registered read data.
module lpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/linear_probe_id_table.sv
// Key to serial id table with open addressing and linear probing.
//
// The req channel carries one beat per operation (op, key); the rsp channel
// returns exactly one beat with the id for each request, in order.
// Assign gives the key a fresh nonzero serial id, find returns the key's id
// or 0, retire frees the key's slot and returns 0. A null key or an unknown
// op returns 0 at once and leaves the table alone.
// After reset the block sweeps the slot memory to empty, one slot a cycle;
// req.ready stays low during that sweep.
// Per request: the home slot (key >> 4) mod SLOTS comes from a 4-bit-a-cycle
// remainder unit (none when SLOTS is a power of two); then the home slot is
// read, one slot is probed per cycle, and the result is handed to the output
// register. The slot memory's single read port sets the probe rate.
// The block takes one request at a time. A finished beat waits in the output
// register while the next request is already accepted; a stalled receiver
// holds the block only when a second result is ready behind it.
module linear_probe_id_table #(
  parameter int SLOTS = 4096
) (
  input logic        clk,
  input logic        rst,
  lpid_req_if.sink   req,
  lpid_rsp_if.source rsp
);
  import lpid_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
  localparam logic [IW:0] LAST_N = (IW + 1)'(SLOTS - 1);
  localparam logic [IW:0] SLOTS_W = (IW + 1)'(SLOTS);

  state_t state, state_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW:0] n, n_next;
  logic [IW-1:0] home, home_next;
  logic [IW-1:0] tgt, tgt_next;
  logic tgt_ok, tgt_ok_next;
  logic [HASH_W-1:0] kq, kq_next;
  logic [2:0] mcnt, mcnt_next;
  logic [1:0] opr, opr_next;
  logic [KEY_W-1:0] keyr, keyr_next;
  logic [ID_W-1:0] next_serial, next_serial_next;
  logic [ID_W-1:0] res, res_next;
  logic rsp_valid, rsp_valid_next;
  logic [ID_W-1:0] rsp_id, rsp_id_next;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  lpid_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.id = rsp_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur <= '0;
      next_serial <= 32'd1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cur <= cur_next;
      next_serial <= next_serial_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;
    home <= home_next;
    tgt <= tgt_next;
    tgt_ok <= tgt_ok_next;
    kq <= kq_next;
    mcnt <= mcnt_next;
    opr <= opr_next;
    keyr <= keyr_next;
    res <= res_next;
    rsp_id <= rsp_id_next;
  end

  always_comb begin
    logic [IW-1:0] r;
    logic [IW:0] t;
    logic [IW-1:0] step;
    logic [HASH_W-1:0] hashed;
    logic hit, empty, retired, stop;
    logic [IW-1:0] target;
    logic [ID_W-1:0] serial;

    state_next = state;
    cur_next = cur;
    n_next = n;
    home_next = home;
    tgt_next = tgt;
    tgt_ok_next = tgt_ok;
    kq_next = kq;
    mcnt_next = mcnt;
    opr_next = opr;
    keyr_next = keyr;
    next_serial_next = next_serial;
    res_next = res;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_id_next = rsp_id;
    ram_we = 1'b0;
    ram_waddr = cur;
    ram_wdata = '0;
    ram_raddr = cur;

    hashed = req.key[KEY_W-1:HASH_SHIFT];
    step = (cur == LAST) ? '0 : cur + 1'b1;
    hit = (ram_rdata.status == SLOT_ACTIVE) && (ram_rdata.key == keyr);
    empty = (ram_rdata.status == SLOT_EMPTY);
    retired = (ram_rdata.status == SLOT_RETIRED);
    stop = hit || empty || (n == LAST_N);
    serial = (next_serial == '0) ? 32'd1 : next_serial;
    if (hit) begin
      target = cur;
    end else if (tgt_ok) begin
      target = tgt;
    end else if (retired || empty) begin
      target = cur;
    end else begin
      target = home;
    end

    r = home;
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {r, kq[HASH_W-1-i]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      r = t[IW-1:0];
    end

    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wdata.status = SLOT_EMPTY;
        if (cur == LAST) begin
          cur_next = '0;
          state_next = S_IDLE;
        end else begin
          cur_next = step;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          opr_next = req.op;
          keyr_next = req.key;
          n_next = '0;
          tgt_ok_next = 1'b0;
          if (req.key == '0 ||
              (req.op != OP_ASSIGN && req.op != OP_FIND && req.op != OP_RETIRE)) begin
            res_next = '0;
            state_next = S_RESP;
          end else if (POW2) begin
            home_next = hashed[IW-1:0];
            cur_next = hashed[IW-1:0];
            state_next = S_READ;
          end else begin
            kq_next = hashed;
            home_next = '0;
            mcnt_next = '0;
            state_next = S_MOD;
          end
        end
      end
      S_MOD: begin
        home_next = r;
        kq_next = kq << MOD_BITS;
        mcnt_next = mcnt + 1'b1;
        if (mcnt == 3'(MOD_STEPS - 1)) begin
          cur_next = r;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stop) begin
          state_next = S_RESP;
          res_next = '0;
          case (opr)
            OP_ASSIGN: begin
              ram_we = 1'b1;
              ram_waddr = target;
              ram_wdata.status = SLOT_ACTIVE;
              ram_wdata.key = keyr;
              ram_wdata.id = serial;
              next_serial_next = serial + 1'b1;
              res_next = serial;
            end
            OP_FIND: begin
              res_next = hit ? ram_rdata.id : '0;
            end
            default: begin
              if (hit) begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                ram_wdata.status = SLOT_RETIRED;
              end
            end
          endcase
        end else begin
          if (retired && !tgt_ok) begin
            tgt_next = cur;
            tgt_ok_next = 1'b1;
          end
          cur_next = step;
          n_next = n + 1'b1;
          ram_raddr = step;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_id_next = res;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
